// ===== rtl/core/kss_pkg.sv =====
// shared types and constants for the keypoint spread score core
package kss_pkg;

    localparam int CFG_W    = 14;
    localparam int COORD_W  = 13;
    localparam int CNT16_W  = 16;
    localparam int DIV_W    = 14;
    localparam int FRAC_W   = 32;
    localparam int MAG_W    = 31;
    localparam int SCORE_W  = 17;

    localparam logic [MAG_W-1:0]   ONE_Q30    = 31'h4000_0000;
    localparam logic [SCORE_W-1:0] SCORE_MAX  = 17'h1_FFFF;
    localparam logic [31:0]        RECIP_TEN  = 32'hCCCC_CCCD;

    // divider operand selects
    localparam logic [1:0] DIV_CW = 2'd0;
    localparam logic [1:0] DIV_CH = 2'd1;
    localparam logic [1:0] DIV_X  = 2'd2;
    localparam logic [1:0] DIV_Y  = 2'd3;

    // register indexes on the config port
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic       cap;
        logic       cnt_clr;
        logic       cnt_inc;
        logic [1:0] div_sel;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       clr_wr;
        logic       bin_rd;
        logic       bin_wr;
        logic       sw_rd;
        logic       bc_mul;
        logic       sq_mul;
        logic       acc_add;
        logic       den_sq;
        logic       den_mul;
        logic       frac_init;
        logic       frac_step;
        logic       pwr_init;
        logic       pwr_mul;
        logic       pwr_sub;
        logic       prod_mul;
        logic       out_load;
        logic       tot_clear;
    } kss_cmd_t;

    typedef struct packed {
        logic is_end;
        logic full;
        logic bin_last;
        logic div_last;
        logic frac_last;
        logic pwr_done;
        logic out_busy;
    } kss_sts_t;

endpackage

// ===== rtl/core/kss_datapath.sv =====
// datapath: config registers, divider, bin memory, sum of squares, fraction, power, score
module kss_datapath import kss_pkg::*; #(
    parameter int GRID_COLS  = 10,
    parameter int GRID_ROWS  = 10,
    parameter int MAX_POINTS = 65535,
    parameter int MIN_POINTS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kss_cmd_t             cmd_i,
    output kss_sts_t             sts_o,
    input  logic                 s_cmd_i,
    input  logic [COORD_W-1:0]   s_px_i,
    input  logic [COORD_W-1:0]   s_py_i,
    input  logic                 cfg_we_i,
    input  logic                 cfg_index_i,
    input  logic [CFG_W-1:0]     cfg_data_i,
    output logic                 m_valid_o,
    output logic [SCORE_W-1:0]   m_score_o,
    output logic                 m_few_o,
    input  logic                 m_ready_i
);

    localparam int NUM_BINS = GRID_COLS * GRID_ROWS;
    localparam int BIN_W    = $clog2(NUM_BINS);
    localparam int COL_W    = $clog2(GRID_COLS);
    localparam int ROW_W    = $clog2(GRID_ROWS);
    localparam int CNT_W    = (BIN_W > 5) ? BIN_W : 5;
    localparam int BC_W     = CNT16_W + BIN_W;
    localparam int SQ_W     = 2 * BC_W;
    localparam int ACC_W    = SQ_W + 1;
    localparam int DEN_K    = (NUM_BINS - 1) * NUM_BINS;

    logic [CFG_W-1:0]   width_reg, height_reg;
    logic               end_reg;
    logic [COORD_W-1:0] px_reg, py_reg;
    logic [DIV_W-1:0]   cw_reg, ch_reg;
    logic [DIV_W:0]     rem_reg;
    logic [DIV_W-1:0]   quo_reg, dvs_reg;
    logic [COL_W-1:0]   cx_reg;
    logic [ROW_W-1:0]   cy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT16_W-1:0] mem [NUM_BINS];
    logic [CNT16_W-1:0] rd_reg;
    logic [CNT16_W-1:0] total_reg;
    logic [BC_W-1:0]    bc_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [ACC_W-1:0]   acc_reg, den_reg;
    logic [31:0]        nsq_reg;
    logic [ACC_W:0]     fr_reg;
    logic [FRAC_W-1:0]  fq_reg;
    logic               d_one_reg, d_zero_reg;
    logic [MAG_W-1:0]   mag_reg, t_reg;
    logic               neg_reg;
    logic [CNT16_W-1:0] k_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               m_valid_reg, m_few_reg;
    logic [SCORE_W-1:0] m_score_reg;

    // divider operands
    logic [DIV_W-1:0] dvd_mux, dvs_mux;
    always_comb begin
        case (cmd_i.div_sel)
            DIV_CW: begin
                dvd_mux = width_reg;
                dvs_mux = DIV_W'(GRID_COLS);
            end
            DIV_CH: begin
                dvd_mux = height_reg;
                dvs_mux = DIV_W'(GRID_ROWS);
            end
            DIV_X: begin
                dvd_mux = DIV_W'(px_reg);
                dvs_mux = cw_reg;
            end
            default: begin
                dvd_mux = DIV_W'(py_reg);
                dvs_mux = ch_reg;
            end
        endcase
    end

    logic [DIV_W:0]   rem_sh;
    logic             rem_ge;
    assign rem_sh = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, dvs_reg});

    // quotient clamp to last cell; a zero divisor gives all ones and clamps too
    logic [COL_W-1:0] cx_clamp;
    logic [ROW_W-1:0] cy_clamp;
    assign cx_clamp = (quo_reg >= DIV_W'(GRID_COLS)) ? COL_W'(GRID_COLS - 1)
                                                    : quo_reg[COL_W-1:0];
    assign cy_clamp = (quo_reg >= DIV_W'(GRID_ROWS)) ? ROW_W'(GRID_ROWS - 1)
                                                    : quo_reg[ROW_W-1:0];

    logic [BIN_W-1:0] bin_idx;
    assign bin_idx = BIN_W'(int'(cy_reg) * GRID_COLS + int'(cx_reg));

    // memory port muxing
    logic               mem_we, mem_re;
    logic [BIN_W-1:0]   mem_wa, mem_ra;
    logic [CNT16_W-1:0] mem_wd;
    always_comb begin
        mem_we = cmd_i.clr_wr | cmd_i.sw_rd | cmd_i.bin_wr;
        mem_wa = cmd_i.bin_wr ? bin_idx : cnt_reg[BIN_W-1:0];
        mem_wd = cmd_i.bin_wr ? rd_reg + 16'd1 : '0;
        mem_re = cmd_i.bin_rd | cmd_i.sw_rd;
        mem_ra = cmd_i.bin_rd ? bin_idx : cnt_reg[BIN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_ra];
        end
    end

    // bin deviation
    logic [BC_W-1:0] n_ext, diff;
    assign n_ext = BC_W'(total_reg);
    assign diff  = (bc_reg >= n_ext) ? bc_reg - n_ext : n_ext - bc_reg;

    logic [ACC_W-1:0] s_clip;
    assign s_clip = (acc_reg > den_reg) ? den_reg : acc_reg;

    logic [ACC_W:0] fr_sh;
    logic           fr_ge;
    assign fr_sh = {fr_reg[ACC_W-1:0], 1'b0};
    assign fr_ge = (fr_sh >= {1'b0, den_reg});

    // mag*9/10 floored is mag minus ceil(mag/10)
    logic [31:0] ten_in;
    logic [63:0] ten_prod;
    assign ten_in   = 32'(mag_reg) + 32'd9;
    assign ten_prod = 64'(ten_in) * 64'(RECIP_TEN);

    logic [31:0] card;
    logic [63:0] full_prod, pv;
    always_comb begin
        card = neg_reg ? 32'(ONE_Q30) - 32'(mag_reg) : 32'(ONE_Q30) + 32'(mag_reg);
        full_prod = 64'(fq_reg) * 64'(card);
        if (d_zero_reg) begin
            pv = '0;
        end else if (d_one_reg) begin
            pv = 64'(card >> 14);
        end else begin
            pv = full_prod >> 46;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= CFG_W'(640);
            height_reg  <= CFG_W'(480);
            cnt_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we_i) begin
                if (cfg_index_i == CFG_IDX_WIDTH) begin
                    width_reg <= cfg_data_i;
                end else begin
                    height_reg <= cfg_data_i;
                end
            end
            if (cmd_i.cnt_clr) begin
                cnt_reg <= '0;
            end else if (cmd_i.cnt_inc) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd_i.tot_clear) begin
                total_reg <= '0;
            end else if (cmd_i.bin_wr) begin
                total_reg <= total_reg + 16'd1;
            end
            if (cmd_i.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready_i) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.cap) begin
            end_reg <= s_cmd_i;
            px_reg  <= s_px_i;
            py_reg  <= s_py_i;
        end
        if (cmd_i.div_init) begin
            rem_reg <= '0;
            quo_reg <= dvd_mux;
            dvs_reg <= dvs_mux;
        end else if (cmd_i.div_step) begin
            rem_reg <= rem_ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
            quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
        end
        if (cmd_i.div_store) begin
            case (cmd_i.div_sel)
                DIV_CW:  cw_reg <= quo_reg;
                DIV_CH:  ch_reg <= quo_reg;
                DIV_X:   cx_reg <= cx_clamp;
                default: cy_reg <= cy_clamp;
            endcase
        end
        if (cmd_i.bc_mul) begin
            bc_reg <= BC_W'(rd_reg) * BC_W'(NUM_BINS);
        end
        if (cmd_i.sq_mul) begin
            sq_reg <= SQ_W'(diff) * SQ_W'(diff);
        end
        if (cmd_i.den_sq) begin
            nsq_reg <= 32'(total_reg) * 32'(total_reg);
            acc_reg <= '0;
        end else if (cmd_i.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(sq_reg);
        end
        if (cmd_i.den_mul) begin
            den_reg <= ACC_W'(nsq_reg) * ACC_W'(DEN_K);
        end
        if (cmd_i.frac_init) begin
            fr_reg     <= (ACC_W+1)'(den_reg - s_clip);
            fq_reg     <= '0;
            d_one_reg  <= (s_clip == '0);
            d_zero_reg <= (den_reg == '0);
        end else if (cmd_i.frac_step) begin
            fr_reg <= fr_ge ? fr_sh - {1'b0, den_reg} : fr_sh;
            fq_reg <= {fq_reg[FRAC_W-2:0], fr_ge};
        end
        if (cmd_i.pwr_init) begin
            neg_reg <= 1'b0;
            if (total_reg < 16'd3) begin
                mag_reg <= '0;
                k_reg   <= '0;
            end else begin
                mag_reg <= ONE_Q30;
                k_reg   <= total_reg - 16'd3;
            end
        end else if (cmd_i.pwr_sub) begin
            mag_reg <= mag_reg - t_reg;
            neg_reg <= ~neg_reg;
            k_reg   <= k_reg - 16'd1;
        end
        if (cmd_i.pwr_mul) begin
            t_reg <= MAG_W'(ten_prod >> 35);
        end
        if (cmd_i.prod_mul) begin
            score_reg <= (pv > 64'(SCORE_MAX)) ? SCORE_MAX : pv[SCORE_W-1:0];
        end
        if (cmd_i.out_load) begin
            m_few_reg   <= (total_reg < 16'(MIN_POINTS));
            m_score_reg <= (total_reg < 16'(MIN_POINTS)) ? '0 : score_reg;
        end
    end

    always_comb begin
        sts_o.is_end    = end_reg;
        sts_o.full      = (total_reg == 16'(MAX_POINTS));
        sts_o.bin_last  = (cnt_reg == CNT_W'(NUM_BINS - 1));
        sts_o.div_last  = (cnt_reg == CNT_W'(DIV_W - 1));
        sts_o.frac_last = (cnt_reg == CNT_W'(FRAC_W - 1));
        sts_o.pwr_done  = (k_reg == '0) || (mag_reg == '0);
        sts_o.out_busy  = m_valid_reg & ~m_ready_i;
    end

    assign m_valid_o = m_valid_reg;
    assign m_score_o = m_score_reg;
    assign m_few_o   = m_few_reg;

endmodule

// ===== rtl/core/kss_ctrl.sv =====
// controller state machine sequencing the datapath
module kss_ctrl import kss_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  kss_sts_t sts_i,
    input  logic     s_valid_i,
    output logic     s_ready_o,
    output logic     cfg_ready_o,
    output kss_cmd_t cmd_o
);

    localparam logic [4:0] ST_CLR    = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_DISP   = 5'd2;
    localparam logic [4:0] ST_DINIT  = 5'd3;
    localparam logic [4:0] ST_DSTEP  = 5'd4;
    localparam logic [4:0] ST_DSTORE = 5'd5;
    localparam logic [4:0] ST_BRD    = 5'd6;
    localparam logic [4:0] ST_BWR    = 5'd7;
    localparam logic [4:0] ST_DSQ    = 5'd8;
    localparam logic [4:0] ST_DMUL   = 5'd9;
    localparam logic [4:0] ST_SRD    = 5'd10;
    localparam logic [4:0] ST_SBC    = 5'd11;
    localparam logic [4:0] ST_SSQ    = 5'd12;
    localparam logic [4:0] ST_SACC   = 5'd13;
    localparam logic [4:0] ST_FINIT  = 5'd14;
    localparam logic [4:0] ST_FSTEP  = 5'd15;
    localparam logic [4:0] ST_PINIT  = 5'd16;
    localparam logic [4:0] ST_PCHK   = 5'd17;
    localparam logic [4:0] ST_PMUL   = 5'd18;
    localparam logic [4:0] ST_PSUB   = 5'd19;
    localparam logic [4:0] ST_PROD   = 5'd20;
    localparam logic [4:0] ST_OUT    = 5'd21;

    logic [4:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            sel_reg   <= DIV_CW;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign s_ready_o   = (state_reg == ST_IDLE);
    assign cfg_ready_o = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        cmd_o         = '0;
        cmd_o.div_sel = sel_reg;
        case (state_reg)
            ST_CLR: begin
                cmd_o.clr_wr  = 1'b1;
                cmd_o.cnt_inc = 1'b1;
                if (sts_i.bin_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd_o.cap = s_valid_i;
                if (s_valid_i) begin
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (sts_i.is_end) begin
                    state_next = ST_DSQ;
                end else if (sts_i.full) begin
                    state_next = ST_IDLE;
                end else begin
                    sel_next   = DIV_CW;
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT: begin
                cmd_o.div_init = 1'b1;
                cmd_o.cnt_clr  = 1'b1;
                state_next     = ST_DSTEP;
            end
            ST_DSTEP: begin
                cmd_o.div_step = 1'b1;
                cmd_o.cnt_inc  = 1'b1;
                if (sts_i.div_last) begin
                    state_next = ST_DSTORE;
                end
            end
            ST_DSTORE: begin
                cmd_o.div_store = 1'b1;
                if (sel_reg == DIV_Y) begin
                    state_next = ST_BRD;
                end else begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_DINIT;
                end
            end
            ST_BRD: begin
                cmd_o.bin_rd = 1'b1;
                state_next   = ST_BWR;
            end
            ST_BWR: begin
                cmd_o.bin_wr = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_DSQ: begin
                cmd_o.den_sq  = 1'b1;
                cmd_o.cnt_clr = 1'b1;
                state_next    = ST_DMUL;
            end
            ST_DMUL: begin
                cmd_o.den_mul = 1'b1;
                state_next    = ST_SRD;
            end
            ST_SRD: begin
                cmd_o.sw_rd = 1'b1;
                state_next  = ST_SBC;
            end
            ST_SBC: begin
                cmd_o.bc_mul = 1'b1;
                state_next   = ST_SSQ;
            end
            ST_SSQ: begin
                cmd_o.sq_mul = 1'b1;
                state_next   = ST_SACC;
            end
            ST_SACC: begin
                cmd_o.acc_add = 1'b1;
                cmd_o.cnt_inc = 1'b1;
                state_next    = sts_i.bin_last ? ST_FINIT : ST_SRD;
            end
            ST_FINIT: begin
                cmd_o.frac_init = 1'b1;
                cmd_o.cnt_clr   = 1'b1;
                state_next      = ST_FSTEP;
            end
            ST_FSTEP: begin
                cmd_o.frac_step = 1'b1;
                cmd_o.cnt_inc   = 1'b1;
                if (sts_i.frac_last) begin
                    state_next = ST_PINIT;
                end
            end
            ST_PINIT: begin
                cmd_o.pwr_init = 1'b1;
                state_next     = ST_PCHK;
            end
            ST_PCHK: begin
                state_next = sts_i.pwr_done ? ST_PROD : ST_PMUL;
            end
            ST_PMUL: begin
                cmd_o.pwr_mul = 1'b1;
                state_next    = ST_PSUB;
            end
            ST_PSUB: begin
                cmd_o.pwr_sub = 1'b1;
                state_next    = ST_PCHK;
            end
            ST_PROD: begin
                cmd_o.prod_mul = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                if (!sts_i.out_busy) begin
                    cmd_o.out_load  = 1'b1;
                    cmd_o.tot_clear = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/keypoint_spread_score_core.sv =====
// top level of the keypoint spread score core
//
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+------------------------------------------
// s_       | in  | s_tvalid / s_tready  | tdata point_x, point_y; tuser cmd
// m_       | out | m_tvalid / m_tready  | tdata score; tuser too_few
// cfg_     | in  | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// one item at a time; an add item runs four passes of the shared 14-step restoring
// divider (cell width, cell height, column, row) plus a read and a write of the bin
// memory
// an end item forms the denominator, then runs the sum-of-squares walk over every bin
// (read, scale, square, accumulate), 32 fraction steps and k <= ~200 power steps
// (check, multiply, subtract) until the term vanishes
// after reset a clearing pass zeroes every bin; no item or config write is taken
// meanwhile
// a finished result waits in the output register while the next add items are taken;
// a later end item holds in its last state until that result is taken
module keypoint_spread_score_core import kss_pkg::*; #(
    parameter int GRID_COLS  = 10,
    parameter int GRID_ROWS  = 10,
    parameter int MAX_POINTS = 65535,
    parameter int MIN_POINTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [12:0] point_x, [25:13] point_y, rest zero
    input  logic        s_tuser,   // [0] cmd: add keypoint or end set
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [16:0] score, rest zero
    output logic        m_tuser,   // [0] too_few
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data
);

    kss_cmd_t           cmd;
    kss_sts_t           sts;
    logic [SCORE_W-1:0] score;

    kss_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sts_i       (sts),
        .s_valid_i   (s_tvalid),
        .s_ready_o   (s_tready),
        .cfg_ready_o (cfg_ready),
        .cmd_o       (cmd)
    );

    kss_datapath #(
        .GRID_COLS  (GRID_COLS),
        .GRID_ROWS  (GRID_ROWS),
        .MAX_POINTS (MAX_POINTS),
        .MIN_POINTS (MIN_POINTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_i       (cmd),
        .sts_o       (sts),
        .s_cmd_i     (s_tuser),
        .s_px_i      (s_tdata[12:0]),
        .s_py_i      (s_tdata[25:13]),
        .cfg_we_i    (cfg_valid & cfg_ready),
        .cfg_index_i (cfg_index),
        .cfg_data_i  (cfg_data),
        .m_valid_o   (m_tvalid),
        .m_score_o   (score),
        .m_few_o     (m_tuser),
        .m_ready_i   (m_tready)
    );

    // score padded to whole bytes
    assign m_tdata = {7'd0, score};

endmodule
